### rtl/lsh_pkg.sv
// Package for the limit-switch homing sequencer.
// Holds the time width, phase codes, register indexes and the config struct.
// No dependencies.
package lsh_pkg;

  // Width of the modular millisecond time arithmetic
  localparam int TIME_WIDTH = 32;

  localparam int SPEED_W = 11;
  localparam int MS_W    = 16;
  localparam int IDX_W   = 3;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [MS_W-1:0] ms_t;

  typedef enum logic [2:0] {
    PH_PREPARE = 3'd0,
    PH_BACKOUT = 3'd1,
    PH_SEARCH  = 3'd2,
    PH_EXIT    = 3'd3,
    PH_PRECISE = 3'd4,
    PH_SETTLE  = 3'd5,
    PH_DONE    = 3'd6,
    PH_FAIL    = 3'd7
  } phase_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_EXIT_SPEED    = 3'd0,
    REG_SEARCH_SPEED  = 3'd1,
    REG_PRECISE_SPEED = 3'd2,
    REG_PHASE_TIMEOUT = 3'd3,
    REG_CLEAR_DWELL   = 3'd4,
    REG_CUT_DEBOUNCE  = 3'd5,
    REG_STOP_SETTLE   = 3'd6,
    REG_ZERO_SETTLE   = 3'd7
  } reg_idx_t;

  localparam speed_t EXIT_SPEED_RST    = -11'sd25;
  localparam speed_t SEARCH_SPEED_RST  = 11'sd60;
  localparam speed_t PRECISE_SPEED_RST = 11'sd5;
  localparam ms_t    PHASE_TIMEOUT_RST = 16'd8000;
  localparam ms_t    CLEAR_DWELL_RST   = 16'd150;
  localparam ms_t    CUT_DEBOUNCE_RST  = 16'd2;
  localparam ms_t    STOP_SETTLE_RST   = 16'd50;
  localparam ms_t    ZERO_SETTLE_RST   = 16'd120;

  // Register file contents handed to the sequencer core
  typedef struct packed {
    speed_t exit_speed;
    speed_t search_speed;
    speed_t precise_speed;
    ms_t    phase_timeout_ms;
    ms_t    clear_dwell_ms;
    ms_t    cut_debounce_ms;
    ms_t    stop_settle_ms;
    ms_t    zero_settle_ms;
  } lsh_cfg_t;

endpackage

### rtl/lsh_ifs.sv
// Channel interfaces of the homing sequencer: command, result and config write.
// Depends on lsh_pkg.
interface lsh_cmd_if import lsh_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_ms;
  logic        in_gate;

  modport source (output valid, op, now_ms, in_gate, input ready);
  modport sink   (input valid, op, now_ms, in_gate, output ready);
endinterface

interface lsh_res_if import lsh_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         speed_write;
  speed_t       speed_rpm;
  logic         motor_en;
  logic         enc_zero;
  logic         angle_zero;
  logic [2:0]   phase;
  logic         done_res;
  logic         failed;

  modport source (output valid, speed_write, speed_rpm, motor_en, enc_zero,
                  angle_zero, phase, done_res, failed, input ready);
  modport sink   (input valid, speed_write, speed_rpm, motor_en, enc_zero,
                  angle_zero, phase, done_res, failed, output ready);
endinterface

interface lsh_cfg_if import lsh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [15:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/lsh_cfg.sv
// Configuration register file of the homing sequencer.
// Depends on lsh_pkg and lsh_ifs.
module lsh_cfg import lsh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lsh_cfg_if.sink   cfg,
  output lsh_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  // Register writes, reset to the default profile
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.exit_speed       <= EXIT_SPEED_RST;
      regs.search_speed     <= SEARCH_SPEED_RST;
      regs.precise_speed    <= PRECISE_SPEED_RST;
      regs.phase_timeout_ms <= PHASE_TIMEOUT_RST;
      regs.clear_dwell_ms   <= CLEAR_DWELL_RST;
      regs.cut_debounce_ms  <= CUT_DEBOUNCE_RST;
      regs.stop_settle_ms   <= STOP_SETTLE_RST;
      regs.zero_settle_ms   <= ZERO_SETTLE_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_EXIT_SPEED:    regs.exit_speed       <= speed_t'(cfg.data[SPEED_W-1:0]);
        REG_SEARCH_SPEED:  regs.search_speed     <= speed_t'(cfg.data[SPEED_W-1:0]);
        REG_PRECISE_SPEED: regs.precise_speed    <= speed_t'(cfg.data[SPEED_W-1:0]);
        REG_PHASE_TIMEOUT: regs.phase_timeout_ms <= cfg.data;
        REG_CLEAR_DWELL:   regs.clear_dwell_ms   <= cfg.data;
        REG_CUT_DEBOUNCE:  regs.cut_debounce_ms  <= cfg.data;
        REG_STOP_SETTLE:   regs.stop_settle_ms   <= cfg.data;
        REG_ZERO_SETTLE:   regs.zero_settle_ms   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/lsh_core.sv
// Homing phase sequencer: state registers, next-state logic and result register.
// Depends on lsh_pkg and lsh_ifs.
module lsh_core import lsh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lsh_cfg_t  regs,
  lsh_cmd_if.sink   cmd,
  lsh_res_if.source res
);

  phase_t phase, phase_next;
  time_t  entry_time, entry_time_next;
  time_t  deadline, deadline_next;
  logic   armed, armed_next;
  logic   zero_issued, zero_issued_next;

  logic   sw, en, sz, az;
  speed_t spd;

  time_t  now_t;
  time_t  elapsed;
  time_t  since_deadline;
  logic   reached;
  logic   moving;
  logic   timed_out;
  logic   dwell_cond;
  ms_t    dwell_len;
  logic   dwell_fire;
  logic   accept;

  // Result register frees up when empty or being taken
  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  // Modular time compares
  assign now_t          = time_t'(cmd.now_ms);
  assign elapsed        = now_t - entry_time;
  assign since_deadline = now_t - deadline;
  assign reached        = !since_deadline[TIME_WIDTH-1];
  assign moving         = (phase == PH_BACKOUT) || (phase == PH_SEARCH) ||
                          (phase == PH_EXIT) || (phase == PH_PRECISE);
  assign timed_out      = moving && (elapsed > time_t'(regs.phase_timeout_ms));

  // Dwell: gate clear on backout/exit, gate held on precise cut-in
  assign dwell_cond = (phase == PH_PRECISE) ? cmd.in_gate : !cmd.in_gate;
  assign dwell_len  = (phase == PH_PRECISE) ? regs.cut_debounce_ms : regs.clear_dwell_ms;
  assign dwell_fire = dwell_cond && armed && reached;

  // Next state and commands for one item
  always_comb begin
    phase_next       = phase;
    entry_time_next  = entry_time;
    deadline_next    = deadline;
    armed_next       = armed;
    zero_issued_next = zero_issued;
    sw  = 1'b0;
    spd = '0;
    en  = 1'b0;
    sz  = 1'b0;
    az  = 1'b0;
    if (cmd.op) begin
      phase_next       = PH_PREPARE;
      entry_time_next  = now_t;
      armed_next       = 1'b0;
      deadline_next    = '0;
      zero_issued_next = 1'b0;
    end else if (phase != PH_DONE && phase != PH_FAIL) begin
      if (timed_out) begin
        sw         = 1'b1;
        phase_next = PH_FAIL;
      end else begin
        // dwell arming shared by backout, exit and precise
        if (moving && phase != PH_SEARCH) begin
          if (!dwell_cond) begin
            armed_next = 1'b0;
          end else if (!armed) begin
            armed_next    = 1'b1;
            deadline_next = now_t + time_t'(dwell_len);
          end
        end
        unique case (phase)
          PH_PREPARE: begin
            en              = 1'b1;
            sw              = 1'b1;
            entry_time_next = now_t;
            armed_next      = 1'b0;
            if (cmd.in_gate) begin
              spd        = regs.exit_speed;
              phase_next = PH_BACKOUT;
            end else begin
              spd        = regs.search_speed;
              phase_next = PH_SEARCH;
            end
          end
          PH_BACKOUT: begin
            if (dwell_fire) begin
              sw              = 1'b1;
              spd             = regs.search_speed;
              phase_next      = PH_SEARCH;
              entry_time_next = now_t;
              armed_next      = 1'b0;
            end
          end
          PH_SEARCH: begin
            if (cmd.in_gate) begin
              sw              = 1'b1;
              spd             = regs.exit_speed;
              phase_next      = PH_EXIT;
              entry_time_next = now_t;
              armed_next      = 1'b0;
            end
          end
          PH_EXIT: begin
            if (dwell_fire) begin
              sw              = 1'b1;
              spd             = regs.precise_speed;
              phase_next      = PH_PRECISE;
              entry_time_next = now_t;
              armed_next      = 1'b0;
            end
          end
          PH_PRECISE: begin
            if (dwell_fire) begin
              sw               = 1'b1;
              phase_next       = PH_SETTLE;
              entry_time_next  = now_t;
              armed_next       = 1'b0;
              deadline_next    = now_t + time_t'(regs.stop_settle_ms);
              zero_issued_next = 1'b0;
            end
          end
          PH_SETTLE: begin
            if (reached) begin
              if (!zero_issued) begin
                sz               = 1'b1;
                zero_issued_next = 1'b1;
                deadline_next    = now_t + time_t'(regs.zero_settle_ms);
              end else begin
                az         = 1'b1;
                phase_next = PH_DONE;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DONE;
      entry_time  <= '0;
      deadline    <= '0;
      armed       <= 1'b0;
      zero_issued <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        entry_time  <= entry_time_next;
        deadline    <= deadline_next;
        armed       <= armed_next;
        zero_issued <= zero_issued_next;
        res.valid   <= 1'b1;
      end else if (res.ready) begin
        res.valid   <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res.speed_write <= sw;
      res.speed_rpm   <= spd;
      res.motor_en    <= en;
      res.enc_zero    <= sz;
      res.angle_zero  <= az;
      res.phase       <= phase_next;
      res.done_res    <= (phase_next == PH_DONE);
      res.failed      <= (phase_next == PH_FAIL);
    end
  end

endmodule

### rtl/limit_switch_homing_sequencer.sv
// Limit-switch homing sequencer, top level.
// The result is registered: result valid rises in the cycle after command accept (one result register).
// Throughput: 1 item per cycle; a new item is taken in any cycle where the
// result register is empty or its item is being read in that same cycle.
// Reset (rst, synchronous): phase done, timers and flags cleared, default
// speed and timing profile loaded into the config registers.
module limit_switch_homing_sequencer import lsh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lsh_cmd_if.sink   cmd,
  lsh_res_if.source res,
  lsh_cfg_if.sink   cfg
);

  lsh_cfg_t regs;

  lsh_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lsh_core u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .cmd  (cmd),
    .res  (res)
  );

endmodule

### test/limit_switch_homing_sequencer_tb.sv
// Self-checking testbench for the limit-switch homing sequencer.
// Drives commands and config writes, predicts every result in-bench and checks them in order.
// Depends on lsh_pkg, the channel interfaces in lsh_ifs and the sequencer top level.
module limit_switch_homing_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsh_pkg::*;

  // One result item as the bench expects it
  typedef struct packed {
    logic   sw;
    speed_t spd;
    logic   en;
    logic   sz;
    logic   az;
    phase_t ph;
    logic   dn;
    logic   fl;
  } homing_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsh_cmd_if cmd_ch ();
  lsh_res_if res_ch ();
  lsh_cfg_if cfg_ch ();

  limit_switch_homing_sequencer i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted sequencer state and register copy
  phase_t m_phase;
  time_t  m_entry;
  time_t  m_deadline;
  logic   m_armed;
  logic   m_zero_sent;
  speed_t m_exit_spd, m_search_spd, m_precise_spd;
  ms_t    m_timeout, m_clear_dwell, m_cut_deb, m_stop_settle, m_zero_settle;

  homing_res_t pending_res[$];
  time_t       stim_ms = '0;
  logic        calm = 1'b0;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_cfg = 0;
  int unsigned n_homed = 0;
  int unsigned n_timed_out = 0;
  int unsigned n_checked = 0;
  int unsigned rx_stall = 0;

  // Deadline counts as reached when now - deadline has a clear top bit
  function automatic logic deadline_hit(time_t now);
    time_t d;
    d = now - m_deadline;
    return !d[TIME_WIDTH-1];
  endfunction

  // Dwell: first qualifying tick arms, later ticks test the deadline
  function automatic logic dwell_done(logic cond, time_t now, ms_t len);
    if (!cond) begin
      m_armed = 1'b0;
      return 1'b0;
    end
    if (!m_armed) begin
      m_armed    = 1'b1;
      m_deadline = now + time_t'(len);
      return 1'b0;
    end
    return deadline_hit(now);
  endfunction

  function automatic void go_phase(phase_t p, time_t now);
    m_phase = p;
    m_entry = now;
    m_armed = 1'b0;
  endfunction

  // Next-result prediction for one accepted command item
  function automatic homing_res_t predict_homing(logic op, time_t now, logic lim);
    homing_res_t r;
    time_t       elapsed;
    logic        moving;
    r = '0;
    if (op) begin
      go_phase(PH_PREPARE, now);
      m_deadline  = '0;
      m_zero_sent = 1'b0;
    end else if (m_phase != PH_DONE && m_phase != PH_FAIL) begin
      moving  = (m_phase >= PH_BACKOUT) && (m_phase <= PH_PRECISE);
      elapsed = now - m_entry;
      if (moving && elapsed > time_t'(m_timeout)) begin
        r.sw    = 1'b1;
        m_phase = PH_FAIL;
        n_timed_out++;
      end else begin
        case (m_phase)
          PH_PREPARE: begin
            r.en = 1'b1;
            r.sw = 1'b1;
            if (lim) begin
              r.spd = m_exit_spd;
              go_phase(PH_BACKOUT, now);
            end else begin
              r.spd = m_search_spd;
              go_phase(PH_SEARCH, now);
            end
          end
          PH_BACKOUT: begin
            if (dwell_done(!lim, now, m_clear_dwell)) begin
              r.sw  = 1'b1;
              r.spd = m_search_spd;
              go_phase(PH_SEARCH, now);
            end
          end
          PH_SEARCH: begin
            if (lim) begin
              r.sw  = 1'b1;
              r.spd = m_exit_spd;
              go_phase(PH_EXIT, now);
            end
          end
          PH_EXIT: begin
            if (dwell_done(!lim, now, m_clear_dwell)) begin
              r.sw  = 1'b1;
              r.spd = m_precise_spd;
              go_phase(PH_PRECISE, now);
            end
          end
          PH_PRECISE: begin
            if (dwell_done(lim, now, m_cut_deb)) begin
              r.sw = 1'b1;
              go_phase(PH_SETTLE, now);
              m_deadline  = now + time_t'(m_stop_settle);
              m_zero_sent = 1'b0;
            end
          end
          default: begin
            // settle: set-zero first, then angle-zero after the second wait
            if (deadline_hit(now)) begin
              if (!m_zero_sent) begin
                r.sz        = 1'b1;
                m_zero_sent = 1'b1;
                m_deadline  = now + time_t'(m_zero_settle);
              end else begin
                r.az    = 1'b1;
                m_phase = PH_DONE;
                n_homed++;
              end
            end
          end
        endcase
      end
    end
    r.ph = m_phase;
    r.dn = (m_phase == PH_DONE);
    r.fl = (m_phase == PH_FAIL);
    return r;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one command item; call right after a falling edge, returns at a falling edge once the item is taken
  task automatic send_item(logic op, logic lim, time_t now);
    int unsigned gap;
    homing_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid   = 1'b1;
    cmd_ch.op      = op;
    cmd_ch.now_ms  = now;
    cmd_ch.in_gate = lim;
    do @(posedge clk); while (!cmd_ch.ready);
    r = predict_homing(op, now, lim);
    pending_res.push_back(r);
    n_items++;
    @(negedge clk);
  endtask

  task automatic tick(logic lim, time_t adv);
    stim_ms = stim_ms + adv;
    send_item(1'b0, lim, stim_ms);
  endtask

  task automatic start_homing(logic lim);
    send_item(1'b1, lim, stim_ms);
  endtask

  // Stop sending and let every expected result come back
  task automatic wait_idle();
    cmd_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] wdata);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_EXIT_SPEED:    m_exit_spd    = wdata[SPEED_W-1:0];
      REG_SEARCH_SPEED:  m_search_spd  = wdata[SPEED_W-1:0];
      REG_PRECISE_SPEED: m_precise_spd = wdata[SPEED_W-1:0];
      REG_PHASE_TIMEOUT: m_timeout     = wdata;
      REG_CLEAR_DWELL:   m_clear_dwell = wdata;
      REG_CUT_DEBOUNCE:  m_cut_deb     = wdata;
      REG_STOP_SETTLE:   m_stop_settle = wdata;
      default:           m_zero_settle = wdata;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_speed_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'($urandom_range(0, 16'hFFFF));
    if (r < 3) return 16'(-1000);
    if (r < 4) return 16'd1000;
    return 16'($signed($urandom_range(0, 2000)) - 1000);
  endfunction

  function automatic logic [15:0] pick_ms(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(lo, hi));
  endfunction

  // Mostly well-formed homing runs: the gate level follows the phase, with noise
  task automatic run_session(int unsigned count);
    int unsigned done_cnt;
    int unsigned step_max;
    int unsigned longest;
    int unsigned r;
    logic        lim;
    time_t       adv;
    done_cnt = 0;
    longest  = 32'(m_clear_dwell);
    if (m_cut_deb > longest) longest = 32'(m_cut_deb);
    if (m_stop_settle > longest) longest = 32'(m_stop_settle);
    if (m_zero_settle > longest) longest = 32'(m_zero_settle);
    step_max = longest / 3 + 3;
    while (done_cnt < count) begin
      r = $urandom_range(0, 99);
      if (m_phase == PH_DONE || m_phase == PH_FAIL) begin
        // ticks here are ignored by the block and not counted
        if (r < 85) begin
          if ($urandom_range(0, 19) == 0) stim_ms = $urandom();
          start_homing(1'($urandom_range(0, 1)));
          done_cnt++;
        end else begin
          tick(1'($urandom_range(0, 1)), $urandom_range(0, step_max));
        end
      end else if (r < 3) begin
        start_homing(1'($urandom_range(0, 1)));
        done_cnt++;
      end else begin
        case (m_phase)
          PH_BACKOUT, PH_EXIT: lim = ($urandom_range(0, 9) == 0);
          PH_SEARCH:           lim = ($urandom_range(0, 3) == 0);
          PH_PRECISE: begin
            if (m_armed) lim = ($urandom_range(0, 9) != 0);
            else lim = ($urandom_range(0, 2) == 0);
          end
          default:             lim = 1'($urandom_range(0, 1));
        endcase
        if (r < 8) lim = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 1) adv = $urandom();
        else if (r < 3) adv = time_t'(m_timeout) + $urandom_range(0, 2);
        else adv = $urandom_range(0, step_max);
        tick(lim, adv);
        done_cnt++;
      end
    end
  endtask

  // Full backout path with the reset profile, gate flips during dwells
  task automatic test_default_homing();
    tick(1'b0, 5);
    start_homing(1'b1);
    tick(1'b1, 1);
    tick(1'b1, 10);
    tick(1'b0, 10);
    tick(1'b0, 150);
    tick(1'b0, 100);
    tick(1'b1, 20);
    tick(1'b0, 5);
    tick(1'b1, 5);
    tick(1'b0, 5);
    tick(1'b0, 149);
    tick(1'b0, 1);
    tick(1'b1, 3);
    tick(1'b0, 1);
    tick(1'b1, 1);
    tick(1'b1, 2);
    tick(1'b0, 49);
    tick(1'b1, 1);
    tick(1'b0, 120);
  endtask

  // Timeout across the 32-bit wrap, ticks in fail, start during a move
  task automatic test_timeout_and_restart();
    stim_ms = 32'hFFFF_FFFF;
    start_homing(1'b0);
    tick(1'b0, 1);
    tick(1'b0, 8000);
    tick(1'b0, 1);
    tick(1'b1, 1);
    start_homing(1'b0);
    tick(1'b0, 1);
    start_homing(1'b1);
    tick(1'b1, 0);
  endtask

  // Register extremes, including raw speed words outside +-1000
  task automatic test_config_extremes();
    logic [15:0] spd_w, ms_w;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0:       begin spd_w = 16'(-1000); ms_w = 16'd0;    end
        1:       begin spd_w = 16'd1000;   ms_w = 16'hFFFF; end
        2:       begin spd_w = 16'hFFFF;   ms_w = 16'hFFFF; end
        default: begin spd_w = 16'h0400;   ms_w = 16'd1;    end
      endcase
      wait_idle();
      write_reg(REG_EXIT_SPEED, spd_w);
      write_reg(REG_SEARCH_SPEED, ~spd_w);
      write_reg(REG_PRECISE_SPEED, spd_w);
      write_reg(REG_PHASE_TIMEOUT, ms_w);
      write_reg(REG_CLEAR_DWELL, ms_w);
      write_reg(REG_CUT_DEBOUNCE, ms_w);
      write_reg(REG_STOP_SETTLE, ms_w);
      write_reg(REG_ZERO_SETTLE, ms_w);
      run_session(40);
    end
  endtask

  // Random profiles, one stretch without idling
  task automatic test_random_profiles();
    logic [15:0] words[8];
    for (int s = 0; s < 7; s++) begin
      wait_idle();
      words[0] = pick_speed_word();
      words[1] = pick_speed_word();
      words[2] = pick_speed_word();
      words[3] = pick_ms(200, 3000);
      words[4] = pick_ms(0, 200);
      words[5] = pick_ms(0, 20);
      words[6] = pick_ms(0, 200);
      words[7] = pick_ms(0, 200);
      for (int k = 0; k < 8; k++) write_reg(reg_idx_t'(k), words[k]);
      calm = (s == 3);
      run_session(100);
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls, driven at the falling edge
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall > 0) begin
        res_ch.ready = 1'b0;
        rx_stall--;
      end else begin
        res_ch.ready = 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    homing_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected", $time);
      end else begin
        want = pending_res.pop_front();
        n_checked++;
        check_field("speed_write", 32'(want.sw), 32'(res_ch.speed_write));
        check_field("speed_rpm", 32'(want.spd), 32'(res_ch.speed_rpm));
        check_field("motor_en", 32'(want.en), 32'(res_ch.motor_en));
        check_field("enc_zero", 32'(want.sz), 32'(res_ch.enc_zero));
        check_field("angle_zero", 32'(want.az), 32'(res_ch.angle_zero));
        check_field("phase", 32'(want.ph), 32'(res_ch.phase));
        check_field("done_res", 32'(want.dn), 32'(res_ch.done_res));
        check_field("failed", 32'(want.fl), 32'(res_ch.failed));
      end
    end
  end

  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.op      = 1'b0;
    cmd_ch.now_ms  = '0;
    cmd_ch.in_gate = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    m_phase       = PH_DONE;
    m_entry       = '0;
    m_deadline    = '0;
    m_armed       = 1'b0;
    m_zero_sent   = 1'b0;
    m_exit_spd    = EXIT_SPEED_RST;
    m_search_spd  = SEARCH_SPEED_RST;
    m_precise_spd = PRECISE_SPEED_RST;
    m_timeout     = PHASE_TIMEOUT_RST;
    m_clear_dwell = CLEAR_DWELL_RST;
    m_cut_deb     = CUT_DEBOUNCE_RST;
    m_stop_settle = STOP_SETTLE_RST;
    m_zero_settle = ZERO_SETTLE_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_homing();
    test_timeout_and_restart();
    test_config_extremes();
    test_random_profiles();
    wait_idle();

    $display("Covered %0d command items and %0d register writes, %0d results checked.",
             n_items, n_cfg, n_checked);
    $display("Homing runs finished: %0d reached home, %0d ended on a phase timeout.",
             n_homed, n_timed_out);
    if (errors == 0) begin
      $display("limit_switch_homing_sequencer_tb: done, clean");
    end else begin
      $display("limit_switch_homing_sequencer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(25_000_000);
    $display("Timeout with %0d results still expected", pending_res.size());
    $display("limit_switch_homing_sequencer_tb: done, errors");
    $finish;
  end

endmodule
